>>> hw/rtl/bcpe_pkg.sv
// Package for the battery charge percent estimator: payload types, register
// indexes, the fixed LiPo discharge curve and shared widths.
// Depends on nothing; every other file of the block imports it.
package bcpe_pkg;

	localparam int TAP_W   = 16;
	localparam int OHMS_W  = 24;
	localparam int PROD_W  = TAP_W + OHMS_W;
	localparam int MV_W    = 16;
	localparam int PC_W    = 7;
	localparam int CMV_W   = 13;
	localparam int SPAN_W  = 9;
	localparam int DP_W    = 4;
	localparam int NUM_W   = SPAN_W + DP_W;
	localparam int QPC_W   = 4;
	localparam int CFG_IDX_W = 2;

	localparam int CURVE_POINTS = 20;

	localparam logic [MV_W-1:0]   MV_FULL  = 16'd4200;
	localparam logic [MV_W-1:0]   MV_EMPTY = 16'd3270;
	localparam logic [PC_W-1:0]   PC_FULL  = 7'd100;
	localparam logic [PC_W-1:0]   PC_EMPTY = 7'd0;
	localparam logic [OHMS_W-1:0] TOTAL_RES_RST = 24'd1500000;
	localparam logic [OHMS_W-1:0] LOWER_RES_RST = 24'd1000000;

	// Curve points, highest voltage first.
	localparam logic [CMV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
		13'd4200, 13'd4110, 13'd4080, 13'd4020, 13'd3980,
		13'd3950, 13'd3910, 13'd3870, 13'd3850, 13'd3840,
		13'd3820, 13'd3800, 13'd3790, 13'd3770, 13'd3750,
		13'd3730, 13'd3710, 13'd3690, 13'd3610, 13'd3270
	};
	localparam logic [PC_W-1:0] CURVE_PC [CURVE_POINTS] = '{
		7'd100, 7'd90, 7'd85, 7'd80, 7'd75,
		7'd70,  7'd65, 7'd60, 7'd55, 7'd50,
		7'd45,  7'd40, 7'd35, 7'd30, 7'd25,
		7'd20,  7'd15, 7'd10, 7'd5,  7'd0
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TOTAL_RES = 2'd0,
		CFG_LOWER_RES = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SOC_EMPTY = 2'd0,
		SOC_FULL  = 2'd1,
		SOC_SEG   = 2'd2
	} soc_cls_t;

	typedef struct packed {
		logic [TAP_W-1:0] tap_millivolts;
		logic             reading_good;
	} in_item_t;

	typedef struct packed {
		logic [PC_W-1:0] charge_percent;
		logic [MV_W-1:0] battery_millivolts;
	} out_item_t;

	typedef struct packed {
		logic nonempty;
		logic full;
		logic two_free;
	} fifo_stat_t;

	typedef struct packed {
		logic            vld;
		logic [MV_W-1:0] mv;
	} mv_item_t;

endpackage

>>> hw/rtl/bcpe_front.sv
// Front end: configuration registers, input acceptance, bad-reading filter
// and the tap-times-total-resistance multiply. Depends on bcpe_pkg.
module bcpe_front
	import bcpe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [OHMS_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	input  fifo_stat_t           fifo_stat,
	output logic                 push,
	output logic [PROD_W-1:0]    push_data,
	output logic [OHMS_W-1:0]    lower_res
);

	logic [OHMS_W-1:0] total_res_q;
	logic [OHMS_W-1:0] lower_res_q;
	logic              vld_s1;
	logic [PROD_W-1:0] prod_s1;
	logic              take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_res_q <= TOTAL_RES_RST;
			lower_res_q <= LOWER_RES_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_TOTAL_RES: total_res_q <= cfg_data;
				CFG_LOWER_RES: lower_res_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The stage register always drains into the queue, so an item may enter
	// only when the queue has room for it and for what the stage holds now.
	assign in_stall = vld_s1 ? !fifo_stat.two_free : fifo_stat.full;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take && in_data.reading_good;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(in_data.tap_millivolts) * PROD_W'(total_res_q);
	end

	assign push      = vld_s1;
	assign push_data = prod_s1;
	assign lower_res = lower_res_q;

endmodule

>>> hw/rtl/bcpe_fifo.sv
// Short queue between the front end and the back end, holding products.
// Depends on bcpe_pkg.
module bcpe_fifo
	import bcpe_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [PROD_W-1:0] push_data,
	input  logic              pop,
	output logic [PROD_W-1:0] head,
	output fifo_stat_t        stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [PROD_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wptr_q;
	logic [PTR_W-1:0]  rptr_q;
	logic [CNT_W-1:0]  count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign head          = mem_q[rptr_q];
	assign stat.nonempty = (count_q != '0);
	assign stat.full     = (count_q == CNT_W'(DEPTH));
	assign stat.two_free = (count_q <= CNT_W'(DEPTH - 2));

endmodule

>>> hw/rtl/bcpe_scale.sv
// Back end, first half: saturation check and a pipelined restoring divider
// that yields the battery voltage, one quotient bit per stage.
// Depends on bcpe_pkg.
module bcpe_scale
	import bcpe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [PROD_W-1:0] prod,
	input  logic [OHMS_W-1:0] lower_res,
	output mv_item_t          volt
);

	logic [MV_W:0]       vld_s;
	logic [MV_W:0]       sat_s;
	logic [PROD_W-1:0]   rem_s [0:MV_W-1];
	logic [MV_W-1:0]     quo_s [0:MV_W];
	logic [MV_W-1:0]     ge;
	logic [PROD_W-1:0]   rem_nx [0:MV_W-1];
	logic [PROD_W-1:0]   dsh [0:MV_W-1];
	logic                sat_in;

	// A quotient of 65536 or more, a zero divisor included, saturates.
	assign sat_in = (prod >= {lower_res, {MV_W{1'b0}}});

	always_comb begin
		for (int k = 0; k < MV_W; k++) begin
			dsh[k]    = PROD_W'(lower_res) << (MV_W - 1 - k);
			ge[k]     = (rem_s[k] >= dsh[k]);
			rem_nx[k] = ge[k] ? (rem_s[k] - dsh[k]) : rem_s[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[MV_W-1:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= prod;
			quo_s[0] <= '0;
			sat_s[0] <= sat_in;
			for (int k = 0; k < MV_W; k++) begin
				quo_s[k+1] <= {quo_s[k][MV_W-2:0], ge[k]};
				sat_s[k+1] <= sat_s[k];
			end
			for (int k = 0; k < MV_W - 1; k++) begin
				rem_s[k+1] <= rem_nx[k];
			end
		end
	end

	assign volt.vld = vld_s[MV_W];
	assign volt.mv  = sat_s[MV_W] ? {MV_W{1'b1}} : quo_s[MV_W];

endmodule

>>> hw/rtl/bcpe_curve.sv
// Back end, second half: curve segment search, interpolation multiply,
// a four-step divider by the segment width and the output register.
// Depends on bcpe_pkg.
module bcpe_curve
	import bcpe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  mv_item_t  volt,
	output logic      out_valid,
	output out_item_t out_data
);

	logic [SPAN_W-1:0] sel_off;
	logic [SPAN_W-1:0] sel_span;
	logic [DP_W-1:0]   sel_dp;
	logic [PC_W-1:0]   sel_lopc;
	soc_cls_t          sel_cls;

	logic              vld_s1;
	soc_cls_t          cls_s1;
	logic [MV_W-1:0]   mv_s1;
	logic [SPAN_W-1:0] off_s1;
	logic [SPAN_W-1:0] span_s1;
	logic [DP_W-1:0]   dp_s1;
	logic [PC_W-1:0]   lopc_s1;

	logic              vld_s2;
	soc_cls_t          cls_s2;
	logic [MV_W-1:0]   mv_s2;
	logic [NUM_W-1:0]  num_s2;
	logic [SPAN_W-1:0] span_s2;
	logic [PC_W-1:0]   lopc_s2;

	logic [QPC_W-1:0]  dvld_s;
	soc_cls_t          dcls_s  [0:QPC_W-1];
	logic [MV_W-1:0]   dmv_s   [0:QPC_W-1];
	logic [NUM_W-1:0]  drem_s  [0:QPC_W-1];
	logic [SPAN_W-1:0] dspan_s [0:QPC_W-1];
	logic [PC_W-1:0]   dlopc_s [0:QPC_W-1];
	logic [QPC_W-1:0]  dquo_s  [0:QPC_W-1];

	logic [NUM_W-1:0]  dvsh    [0:QPC_W-1];
	logic [QPC_W-1:0]  dge;
	logic [NUM_W-1:0]  drem_nx [0:QPC_W-1];
	logic [PC_W-1:0]   pc_final;

	// The first segment that holds the voltage wins, so scan from the bottom
	// of the table up and let the higher segments overwrite.
	always_comb begin
		sel_off  = '0;
		sel_span = '0;
		sel_dp   = '0;
		sel_lopc = '0;
		for (int k = CURVE_POINTS - 2; k >= 0; k--) begin
			if (volt.mv <= MV_W'(CURVE_MV[k]) && volt.mv >= MV_W'(CURVE_MV[k+1])) begin
				sel_span = SPAN_W'(CURVE_MV[k] - CURVE_MV[k+1]);
				sel_dp   = DP_W'(CURVE_PC[k] - CURVE_PC[k+1]);
				sel_lopc = CURVE_PC[k+1];
				sel_off  = SPAN_W'(volt.mv - MV_W'(CURVE_MV[k+1]));
			end
		end
		if (volt.mv >= MV_FULL) begin
			sel_cls = SOC_FULL;
		end else if (volt.mv <= MV_EMPTY) begin
			sel_cls = SOC_EMPTY;
		end else begin
			sel_cls = SOC_SEG;
		end
	end

	always_comb begin
		for (int j = 0; j < QPC_W; j++) begin
			dvsh[j]    = NUM_W'(dspan_s[j]) << (QPC_W - 1 - j);
			dge[j]     = (drem_s[j] >= dvsh[j]);
			drem_nx[j] = dge[j] ? (drem_s[j] - dvsh[j]) : drem_s[j];
		end
	end

	always_comb begin
		case (dcls_s[QPC_W-1])
			SOC_FULL:  pc_final = PC_FULL;
			SOC_EMPTY: pc_final = PC_EMPTY;
			SOC_SEG:   pc_final = dlopc_s[QPC_W-1]
				+ PC_W'({dquo_s[QPC_W-1][QPC_W-2:0], dge[QPC_W-1]});
			default:   pc_final = PC_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			dvld_s    <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= volt.vld;
			vld_s2    <= vld_s1;
			dvld_s    <= {dvld_s[QPC_W-2:0], vld_s2};
			out_valid <= dvld_s[QPC_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cls_s1  <= sel_cls;
			mv_s1   <= volt.mv;
			off_s1  <= sel_off;
			span_s1 <= sel_span;
			dp_s1   <= sel_dp;
			lopc_s1 <= sel_lopc;

			cls_s2  <= cls_s1;
			mv_s2   <= mv_s1;
			num_s2  <= NUM_W'(off_s1) * NUM_W'(dp_s1);
			span_s2 <= span_s1;
			lopc_s2 <= lopc_s1;

			dcls_s[0]  <= cls_s2;
			dmv_s[0]   <= mv_s2;
			drem_s[0]  <= num_s2;
			dspan_s[0] <= span_s2;
			dlopc_s[0] <= lopc_s2;
			dquo_s[0]  <= '0;
			for (int j = 0; j < QPC_W - 1; j++) begin
				dcls_s[j+1]  <= dcls_s[j];
				dmv_s[j+1]   <= dmv_s[j];
				drem_s[j+1]  <= drem_nx[j];
				dspan_s[j+1] <= dspan_s[j];
				dlopc_s[j+1] <= dlopc_s[j];
				dquo_s[j+1]  <= {dquo_s[j][QPC_W-2:0], dge[j]};
			end

			out_data.charge_percent     <= pc_final;
			out_data.battery_millivolts <= dmv_s[QPC_W-1];
		end
	end

endmodule

>>> hw/rtl/battery_charge_percent_estimator_unit.sv
// Battery charge percent estimator, top level. One reading is taken every
// cycle while the output is not stalled, the rate being set by the fully
// pipelined 16-stage voltage divider and 4-stage interpolation divider.
// Reset is asynchronous, active low: it empties the pipeline and queue and
// loads the divider registers with 1500000 and 1000000 ohms. Uses bcpe_pkg
// and the bcpe_ front, fifo, scale and curve parts.
module battery_charge_percent_estimator_unit
	import bcpe_pkg::*;
#(
	parameter int FIFO_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [OHMS_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data
);

	// Front end: holds the two resistance registers, takes a transfer when
	// the queue can absorb it, drops readings flagged as bad and forms the
	// 40-bit product of tap voltage and total resistance in one stage.
	// Back end: one stall-together pipeline. It pulls a product from the
	// queue whenever its last stage is empty or being taken, divides by the
	// lower-leg resistance one quotient bit per stage with saturation at
	// 65535 mV, then looks the voltage up in the discharge curve and
	// interpolates inside the matching segment.

	fifo_stat_t        fifo_stat;
	logic              push;
	logic [PROD_W-1:0] push_data;
	logic [PROD_W-1:0] head;
	logic [OHMS_W-1:0] lower_res;
	logic              back_en;
	logic              pop;
	mv_item_t          volt;

	// The whole back end advances unless a finished result sits unclaimed.
	assign back_en = !out_valid || !out_stall;
	assign pop     = back_en && fifo_stat.nonempty;

	bcpe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.fifo_stat (fifo_stat),
		.push      (push),
		.push_data (push_data),
		.lower_res (lower_res)
	);

	bcpe_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (fifo_stat)
	);

	bcpe_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (back_en),
		.in_vld    (pop),
		.prod      (head),
		.lower_res (lower_res),
		.volt      (volt)
	);

	bcpe_curve u_curve (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (back_en),
		.volt      (volt),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

>>> hw/rtl/bcpe_checker.sv
// Port-level checker for the battery charge percent estimator, bound to the
// top level. Depends on bcpe_pkg.
module bcpe_checker
	import bcpe_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input out_item_t            out_data
);

	// A stalled result stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.charge_percent <= PC_FULL)
		else $error("charge above 100 percent");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.battery_millivolts >= MV_FULL
		|-> out_data.charge_percent == PC_FULL)
		else $error("full battery not reported as 100 percent");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.battery_millivolts <= MV_EMPTY
		|-> out_data.charge_percent == PC_EMPTY)
		else $error("empty battery not reported as 0 percent");

endmodule

bind battery_charge_percent_estimator_unit bcpe_checker u_bcpe_checker (.*);

>>> dv/battery_charge_percent_estimator_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for battery_charge_percent_estimator_unit: random and directed readings
// checked against a scoreboard that predicts voltage and charge per reading.
// Depends on bcpe_pkg and the estimator RTL only.
module battery_charge_percent_estimator_unit_tb;
	import bcpe_pkg::*;

	// Pipeline depth given for the block; used to let the pipeline settle.
	localparam int PIPE_LATENCY = 25;
	// The watchdog ends the run after this many cycles with no transfer on either side.
	localparam int IDLE_LIMIT   = 4000;
	// The long receiver hold starts once this many readings went in.
	localparam int HOLD_AT      = 250;
	localparam int HOLD_CYCLES  = 300;
	localparam int MAX_REPORTS  = 10;

	// Register indexes that select no register; writes to them must be dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

	// LiPo discharge curve, highest voltage first, as millivolts and percent.
	localparam int KNEES = 20;
	localparam int unsigned KNEE_MV [KNEES] = '{
		4200, 4110, 4080, 4020, 3980, 3950, 3910, 3870, 3850, 3840,
		3820, 3800, 3790, 3770, 3750, 3730, 3710, 3690, 3610, 3270
	};
	localparam int unsigned KNEE_PC [KNEES] = '{
		100, 90, 85, 80, 75, 70, 65, 60, 55, 50,
		45,  40, 35, 30, 25, 20, 15, 10, 5,  0
	};
	localparam int unsigned LIPO_FULL_MV  = 4200;
	localparam int unsigned LIPO_EMPTY_MV = 3270;
	localparam longint unsigned SAT_MV    = 65535;

	// The scoreboard keeps its own copy of the two divider registers and a
	// queue of the results that good readings must produce, oldest first.
	class charge_scoreboard;
		logic [OHMS_W-1:0] total_res;
		logic [OHMS_W-1:0] lower_res;
		out_item_t expected_charges[$];
		int bad_results;

		function new();
			total_res = 24'd1500000;
			lower_res = 24'd1000000;
			expected_charges = {};
			bad_results = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [OHMS_W-1:0] val);
			if (idx == CFG_TOTAL_RES) begin
				total_res = val;
			end else if (idx == CFG_LOWER_RES) begin
				lower_res = val;
			end
		endfunction

		// Percentage from the curve: clamp at both ends, otherwise interpolate
		// with floor division in the first segment that holds the voltage.
		function logic [PC_W-1:0] charge_of(int unsigned mv);
			int unsigned hi_mv;
			int unsigned lo_mv;
			int unsigned hi_pc;
			int unsigned lo_pc;
			int unsigned span;
			if (mv >= LIPO_FULL_MV) return 7'd100;
			if (mv <= LIPO_EMPTY_MV) return 7'd0;
			for (int k = 0; k + 1 < KNEES; k++) begin
				hi_mv = KNEE_MV[k];
				lo_mv = KNEE_MV[k + 1];
				hi_pc = KNEE_PC[k];
				lo_pc = KNEE_PC[k + 1];
				if (mv <= hi_mv && mv >= lo_mv) begin
					span = hi_mv - lo_mv;
					if (span == 0) return PC_W'(hi_pc);
					return PC_W'(lo_pc + ((mv - lo_mv) * (hi_pc - lo_pc)) / span);
				end
			end
			return 7'd0;
		endfunction

		function out_item_t estimate_charge(logic [TAP_W-1:0] tap);
			out_item_t est;
			longint unsigned scaled;
			if (lower_res == 0) begin
				scaled = SAT_MV;
			end else begin
				scaled = (longint'(tap) * longint'(total_res)) / longint'(lower_res);
			end
			if (scaled > SAT_MV) scaled = SAT_MV;
			est.battery_millivolts = MV_W'(scaled);
			est.charge_percent = charge_of(int'(scaled));
			return est;
		endfunction

		function void note_reading(in_item_t reading);
			if (reading.reading_good) begin
				expected_charges.push_back(estimate_charge(reading.tap_millivolts));
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_charges.size() == 0) begin
				bad_results++;
				if (bad_results <= MAX_REPORTS) begin
					$display("%0t: unexpected result pct=%0d mv=%0d", $realtime,
						got.charge_percent, got.battery_millivolts);
				end
				return;
			end
			want = expected_charges.pop_front();
			if (got.charge_percent !== want.charge_percent ||
				got.battery_millivolts !== want.battery_millivolts) begin
				bad_results++;
				if (bad_results <= MAX_REPORTS) begin
					$display("%0t: mismatch pct exp=%0d got=%0d, mv exp=%0d got=%0d",
						$realtime, want.charge_percent, got.charge_percent,
						want.battery_millivolts, got.battery_millivolts);
				end
			end
		endfunction

		function int pending();
			return expected_charges.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [OHMS_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;

	charge_scoreboard sb;
	int readings_taken = 0;
	int idle_cycles = 0;

	battery_charge_percent_estimator_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Monitor. All inputs change by nonblocking assignment at the rising edge,
	// so at the edge this block sees the values that the block itself latches.
	// Register writes, input transfers and output transfers all go to the
	// scoreboard here, and the watchdog counts edges with no transfer at all.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_write) sb.write_register(cfg_index, cfg_data);
			if (in_valid && !in_stall) begin
				sb.note_reading(in_data);
				readings_taken++;
			end
			if (out_valid && !out_stall) sb.check_result(out_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL battery_charge_percent_estimator_unit");
				$finish;
			end
		end
	end

	// Receiver. It changes its stall behavior at random intervals: free
	// running, light stalls, heavy stalls, or alternating stalls. Once, after
	// enough readings went in, it holds off for a long stretch so that the
	// pipeline and queue fill up and the block stalls its input.
	initial begin
		int mode;
		int stretch;
		bit held;
		held = 1'b0;
		out_stall = 1'b0;
		wait (arst_n);
		forever begin
			if (!held && readings_taken >= HOLD_AT) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			stretch = $urandom_range(8, 80);
			for (int i = 0; i < stretch; i++) begin
				case (mode)
					0: begin
						out_stall <= 1'b0;
					end
					1: begin
						out_stall <= ($urandom_range(0, 3) == 0);
					end
					2: begin
						out_stall <= ($urandom_range(0, 3) != 0);
					end
					default: begin
						out_stall <= i[0];
					end
				endcase
				@(posedge clk);
			end
		end
	end

	// One register write, then the write enable goes low again before the task
	// returns, so that it never gets two assignments in the same step.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [OHMS_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one reading and returns at the edge where it is transferred.
	// Valid stays high; the caller either offers the next reading or drops it.
	task automatic send_reading(input in_item_t reading);
		in_data <= reading;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// Waits until every expected result is back, then lets the pipeline run
	// dry; bad readings are dropped at the input and leave no result.
	task automatic settle();
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 5) @(posedge clk);
	endtask

	// Most good readings are aimed at a battery voltage near the curve under
	// the current divider setting, so that every segment gets hit; the rest
	// are bad readings, extremes, or taps drawn over the whole range.
	function automatic in_item_t pick_reading();
		in_item_t reading;
		int unsigned roll;
		longint unsigned volts;
		longint unsigned tap;
		roll = $urandom_range(0, 99);
		reading.reading_good = (roll >= 12);
		if (roll >= 40 && sb.total_res != 0 && sb.lower_res != 0) begin
			volts = $urandom_range(3200, 4300);
			tap = volts * sb.lower_res;
			// Rounding the tap up lands exactly on the voltage where it can.
			if ($urandom_range(0, 1)) tap = tap + sb.total_res - 1;
			tap = tap / sb.total_res;
			reading.tap_millivolts = (tap > SAT_MV) ? 16'hFFFF : TAP_W'(tap);
		end else if (roll >= 34) begin
			reading.tap_millivolts = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		end else begin
			reading.tap_millivolts = TAP_W'($urandom_range(0, 65535));
		end
		return reading;
	endfunction

	// Random readings in bursts of random length, with random gaps between
	// them; about a quarter of the bursts follow the previous one directly.
	task automatic run_readings(input int count);
		int burst_left;
		int gap;
		burst_left = 0;
		for (int i = 0; i < count; i++) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 48);
			end
			send_reading(pick_reading());
			burst_left--;
		end
		in_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [OHMS_W-1:0] full, input logic [OHMS_W-1:0] lower,
		input int count);
		settle();
		write_register(CFG_TOTAL_RES, full);
		write_register(CFG_LOWER_RES, lower);
		run_readings(count);
	endtask

	// Directed readings under the reset divider (scale 1.5): both ends of the
	// tap range, the exact saturation point and one past it, the full and
	// empty thresholds and their neighbors, several curve points, and bad
	// readings at both extremes.
	localparam int DIRECTED = 20;
	localparam logic [TAP_W-1:0] DIRECTED_TAP [DIRECTED] = '{
		16'd0, 16'd65535, 16'd43690, 16'd43691, 16'd2800,
		16'd2799, 16'd2180, 16'd2181, 16'd2740, 16'd2720,
		16'd2567, 16'd2560, 16'd2460, 16'd2407, 16'd2300,
		16'h5555, 16'hAAAA, 16'd0, 16'd65535, 16'd2500
	};
	localparam bit DIRECTED_GOOD [DIRECTED] = '{
		1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
		1, 1, 1, 1, 1, 1, 1, 0, 0, 0
	};

	initial begin
		in_item_t reading;
		logic [OHMS_W-1:0] lower;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_TOTAL_RES;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Back to back, with no gaps.
		for (int i = 0; i < DIRECTED; i++) begin
			reading.tap_millivolts = DIRECTED_TAP[i];
			reading.reading_good = DIRECTED_GOOD[i];
			send_reading(reading);
		end
		in_valid <= 1'b0;
		settle();

		// Writes to indexes that select no register must leave the reset
		// divider in place, which the next batch of readings checks.
		write_register(CFG_UNUSED_A, 24'd0);
		write_register(CFG_UNUSED_B, 24'd1);
		run_readings(500);

		// Unity scale, then the extremes: the largest ratio saturates almost
		// everything and the smallest gives zero volts. A zero total
		// resistance gives zero volts, a zero lower leg saturates.
		run_phase(24'd1000000, 24'd1000000, 220);
		run_phase(24'hFFFFFF, 24'd1, 60);
		run_phase(24'd1, 24'hFFFFFF, 60);
		run_phase(24'd0, OHMS_W'($urandom_range(1, 10000000)), 40);
		run_phase(OHMS_W'($urandom_range(1, 10000000)), 24'd0, 40);

		// Random dividers with a ratio between one and eight, so that aimed
		// readings still reach the curve.
		for (int p = 0; p < 4; p++) begin
			lower = OHMS_W'($urandom_range(1000, 2000000));
			run_phase(OHMS_W'($urandom_range(lower, lower * 8)), lower, 130);
		end

		settle();
		if (sb.bad_results == 0 && sb.pending() == 0) begin
			$display("PASS battery_charge_percent_estimator_unit");
		end else begin
			$display("FAIL battery_charge_percent_estimator_unit");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/bcpe_pkg.sv
hw/rtl/bcpe_front.sv
hw/rtl/bcpe_fifo.sv
hw/rtl/bcpe_scale.sv
hw/rtl/bcpe_curve.sv
hw/rtl/battery_charge_percent_estimator_unit.sv
hw/rtl/bcpe_checker.sv
dv/battery_charge_percent_estimator_unit_tb.sv
